// ----- sv/abd2_pkg.sv -----
// ----------------------------------------------------------------------------
// abd2_pkg
// Shared constants, types and helpers for the 2x2 ARGB box downscaler.
// ----------------------------------------------------------------------------
package abd2_pkg;

  localparam int unsigned MAX_SOURCE_WIDTH  = 2048;
  localparam int unsigned MAX_SOURCE_HEIGHT = 4096;
  localparam int unsigned MIN_DIM           = 2;

  localparam int unsigned PIX_W    = 32;
  localparam int unsigned SUM_W    = 9;
  localparam int unsigned PSUM_W   = 4 * SUM_W;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SRC_W_BITS = 12;
  localparam int unsigned SRC_H_BITS = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_OPAQUE  = 2'd2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  // Beat handed from the scan stage to the output pipeline
  typedef struct packed {
    logic              avg;     // bottom-right pixel of a block: line store read issued
    logic              last;    // final block of the frame
    logic [PSUM_W-1:0] sums;    // pair sums of the bottom row
  } beat_t;

  // Per-channel sums of two pixels, four 9-bit fields, alpha highest
  function automatic logic [PSUM_W-1:0] pair_sums(input logic [PIX_W-1:0] p,
                                                  input logic [PIX_W-1:0] q);
    logic [PSUM_W-1:0] r;
    r = '0;
    for (int ch = 0; ch < 4; ch++) begin
      r[ch*SUM_W +: SUM_W] = SUM_W'(p[ch*8 +: 8]) + SUM_W'(q[ch*8 +: 8]);
    end
    return r;
  endfunction

  // Sum top and bottom pair sums per channel and truncate by 4
  function automatic logic [PIX_W-1:0] block_avg(input logic [PSUM_W-1:0] top,
                                                 input logic [PSUM_W-1:0] bot);
    logic [PIX_W-1:0]  r;
    logic [SUM_W:0]    t;
    r = '0;
    for (int ch = 0; ch < 4; ch++) begin
      t = (SUM_W+1)'(top[ch*SUM_W +: SUM_W]) + (SUM_W+1)'(bot[ch*SUM_W +: SUM_W]);
      r[ch*8 +: 8] = t[SUM_W:2];
    end
    return r;
  endfunction

endpackage

// ----- sv/abd2_line_ram.sv -----
// ----------------------------------------------------------------------------
// abd2_line_ram
// Single-port line store of top-row pair sums, registered read data.
// ----------------------------------------------------------------------------
module abd2_line_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               addr_i,
  input  logic [abd2_pkg::PSUM_W-1:0] wdata_i,
  output logic [abd2_pkg::PSUM_W-1:0] rdata_o
);

  logic [abd2_pkg::PSUM_W-1:0] mem [DEPTH];
  logic [abd2_pkg::PSUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/abd2_scan.sv -----
// ----------------------------------------------------------------------------
// abd2_scan
// Raster position tracking, left-pixel hold, pair sums and line store access.
// ----------------------------------------------------------------------------
module abd2_scan #(
  parameter int unsigned MAX_SOURCE_WIDTH  = abd2_pkg::MAX_SOURCE_WIDTH,
  parameter int unsigned MAX_SOURCE_HEIGHT = abd2_pkg::MAX_SOURCE_HEIGHT,
  parameter int unsigned WW = $clog2(MAX_SOURCE_WIDTH + 1),
  parameter int unsigned HW = $clog2(MAX_SOURCE_HEIGHT + 1),
  parameter int unsigned AW = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [abd2_pkg::PIX_W-1:0]  pixel_i,
  input  logic [WW-1:0]               width_i,
  input  logic [HW-1:0]               height_i,
  output logic                        line_we_o,
  output logic                        line_re_o,
  output logic [AW-1:0]               line_addr_o,
  output logic [abd2_pkg::PSUM_W-1:0] line_wdata_o,
  output abd2_pkg::beat_t             beat_o
);

  localparam int unsigned XW = $clog2(MAX_SOURCE_WIDTH);
  localparam int unsigned YW = $clog2(MAX_SOURCE_HEIGHT);

  logic [XW-1:0]              col_q, col_d;
  logic [YW-1:0]              row_q, row_d;
  logic [abd2_pkg::PIX_W-1:0] left_q;

  logic [WW-1:0] x_ext, x_nxt, even_w;
  logic [HW-1:0] y_ext, y_nxt, even_h;
  logic          in_blk, odd_col, odd_row;
  logic [abd2_pkg::PSUM_W-1:0] sums;

  always_comb begin
    x_ext   = WW'(col_q);
    y_ext   = HW'(row_q);
    x_nxt   = x_ext + WW'(1);
    y_nxt   = y_ext + HW'(1);
    even_w  = {width_i[WW-1:1], 1'b0};
    even_h  = {height_i[HW-1:1], 1'b0};
    in_blk  = (x_ext < even_w) && (y_ext < even_h);
    odd_col = col_q[0];
    odd_row = row_q[0];
    sums    = abd2_pkg::pair_sums(left_q, pixel_i);

    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      // counts left past a smaller limit by a config change wrap here too
      if (x_nxt >= width_i) begin
        col_d = '0;
        row_d = (y_nxt >= height_i) ? '0 : y_nxt[YW-1:0];
      end else begin
        col_d = x_nxt[XW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept_i && in_blk && !odd_col) begin
        left_q <= pixel_i;
      end
    end
  end

  // Top row writes its pair sums; bottom row reads them back on its odd column.
  // A write and the read of the same entry are at least one row apart.
  assign line_we_o    = accept_i && in_blk && odd_col && !odd_row;
  assign line_re_o    = accept_i && in_blk && odd_col && odd_row;
  assign line_addr_o  = AW'(col_q >> 1);
  assign line_wdata_o = sums;

  always_comb begin
    beat_o.avg  = in_blk && odd_col && odd_row;
    beat_o.last = (x_ext == even_w - WW'(1)) && (y_ext == even_h - HW'(1));
    beat_o.sums = sums;
  end

endmodule

// ----- sv/abd2_out_stage.sv -----
// ----------------------------------------------------------------------------
// abd2_out_stage
// Read stage awaits line store data, then averages into the output register.
// ----------------------------------------------------------------------------
module abd2_out_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  abd2_pkg::beat_t             beat_i,
  input  logic [abd2_pkg::PSUM_W-1:0] top_i,
  input  logic                        opaque_i,
  output logic                        ready_o,
  output logic                        valid_o,
  output logic [abd2_pkg::PIX_W-1:0]  pixel_o,
  output logic                        last_o,
  input  logic                        ready_i
);

  logic                        s1_vld_q;
  logic                        s1_last_q;
  logic [abd2_pkg::PSUM_W-1:0] s1_sums_q;
  logic                        out_vld_q;
  logic                        out_last_q;
  logic [abd2_pkg::PIX_W-1:0]  out_pix_q;
  logic                        s1_adv;
  logic [abd2_pkg::PIX_W-1:0]  avg;

  assign s1_adv  = !out_vld_q || ready_i;
  assign ready_o = !s1_vld_q || s1_adv;

  always_comb begin
    avg = abd2_pkg::block_avg(top_i, s1_sums_q);
    if (opaque_i) begin
      avg[31:24] = abd2_pkg::ALPHA_OPAQUE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (accept_i) begin
        s1_vld_q <= beat_i.avg;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_vld_q && s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && beat_i.avg) begin
      s1_last_q <= beat_i.last;
      s1_sums_q <= beat_i.sums;
    end
    if (s1_vld_q && s1_adv) begin
      out_pix_q  <= avg;
      out_last_q <= s1_last_q;
    end
  end

  assign valid_o = out_vld_q;
  assign pixel_o = out_pix_q;
  assign last_o  = out_last_q;

endmodule

// ----- sv/argb_box_downscale_2x2_unit.sv -----
// ----------------------------------------------------------------------------
// argb_box_downscale_2x2_unit
// 2x2 box-filter downscaler for ARGB8888 raster streams.
// ----------------------------------------------------------------------------
// Source pixels enter on s_axis one beat per pixel in raster order; every
// aligned 2x2 block gives one averaged pixel on m_axis (per channel sum of
// four, truncated by 4), tlast high on the final block of the frame. A
// trailing odd column or row is taken and dropped.
// Throughput: one pixel per cycle while the output is not stalled. The line
// store takes one access per pixel pair (a write on the top row, a read on
// the bottom row). The accepted bottom-right pixel starts the line store
// read and fills the read stage; the average then goes into the output
// register. Configuration (width, height, opaque alpha) goes in through
// cfg_we_i while the stream is idle: the user keeps to this, the block does
// not enforce it. Width and height are clamped to [2, MAX]. Reset clears the
// raster position and the pipeline; the line store needs no clearing. A
// stalled receiver holds the output beat; one more result waits in the read
// stage and s_axis_tready drops only when both are full.
module argb_box_downscale_2x2_unit #(
  parameter int unsigned MAX_SOURCE_WIDTH  = abd2_pkg::MAX_SOURCE_WIDTH,
  parameter int unsigned MAX_SOURCE_HEIGHT = abd2_pkg::MAX_SOURCE_HEIGHT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [abd2_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [abd2_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,   // pixel_in[31:0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [31:0]                    m_axis_tdata,   // pixel_out[31:0]
  output logic                           m_axis_tlast    // frame_last
);

  localparam int unsigned LINE_DEPTH = MAX_SOURCE_WIDTH / 2;
  localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned WW = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int unsigned CWW = (WW > abd2_pkg::SRC_W_BITS) ? WW : abd2_pkg::SRC_W_BITS;
  localparam int unsigned CHW = (HW > abd2_pkg::SRC_H_BITS) ? HW : abd2_pkg::SRC_H_BITS;

  logic [WW-1:0] width_q, width_d;
  logic [HW-1:0] height_q, height_d;
  logic          opaque_q;
  logic [CWW-1:0] w_raw;
  logic [CHW-1:0] h_raw;

  logic                        accept;
  logic                        line_we, line_re;
  logic [AW-1:0]               line_addr;
  logic [abd2_pkg::PSUM_W-1:0] line_wdata, line_rdata;
  abd2_pkg::beat_t             beat;

  // clamp at write time so the datapath sees legal dimensions only
  always_comb begin
    w_raw = CWW'(cfg_data_i[abd2_pkg::SRC_W_BITS-1:0]);
    h_raw = CHW'(cfg_data_i[abd2_pkg::SRC_H_BITS-1:0]);
    if (w_raw < CWW'(abd2_pkg::MIN_DIM)) begin
      width_d = WW'(abd2_pkg::MIN_DIM);
    end else if (w_raw > CWW'(MAX_SOURCE_WIDTH)) begin
      width_d = WW'(MAX_SOURCE_WIDTH);
    end else begin
      width_d = w_raw[WW-1:0];
    end
    if (h_raw < CHW'(abd2_pkg::MIN_DIM)) begin
      height_d = HW'(abd2_pkg::MIN_DIM);
    end else if (h_raw > CHW'(MAX_SOURCE_HEIGHT)) begin
      height_d = HW'(MAX_SOURCE_HEIGHT);
    end else begin
      height_d = h_raw[HW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(abd2_pkg::MIN_DIM);
      height_q <= HW'(abd2_pkg::MIN_DIM);
      opaque_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        abd2_pkg::CFG_SOURCE_WIDTH:  width_q  <= width_d;
        abd2_pkg::CFG_SOURCE_HEIGHT: height_q <= height_d;
        abd2_pkg::CFG_FORCE_OPAQUE:  opaque_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;

  abd2_scan #(
    .MAX_SOURCE_WIDTH  (MAX_SOURCE_WIDTH),
    .MAX_SOURCE_HEIGHT (MAX_SOURCE_HEIGHT),
    .WW                (WW),
    .HW                (HW),
    .AW                (AW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .pixel_i      (s_axis_tdata),
    .width_i      (width_q),
    .height_i     (height_q),
    .line_we_o    (line_we),
    .line_re_o    (line_re),
    .line_addr_o  (line_addr),
    .line_wdata_o (line_wdata),
    .beat_o       (beat)
  );

  abd2_line_ram #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .re_i    (line_re),
    .addr_i  (line_addr),
    .wdata_i (line_wdata),
    .rdata_o (line_rdata)
  );

  abd2_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .beat_i   (beat),
    .top_i    (line_rdata),
    .opaque_i (opaque_q),
    .ready_o  (s_axis_tready),
    .valid_o  (m_axis_tvalid),
    .pixel_o  (m_axis_tdata),
    .last_o   (m_axis_tlast),
    .ready_i  (m_axis_tready)
  );

endmodule

// ----- sv/abd2_checker.sv -----
// ----------------------------------------------------------------------------
// abd2_checker
// Port-level checks of the downscaler stream behaviour, bound to the top.
// ----------------------------------------------------------------------------
module abd2_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output beat changed while stalled");

  // a fresh output beat follows an accepted pixel through the read stage and output register
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("output beat without a matching input beat");

  // with the output register empty the input side never stalls
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

endmodule

bind argb_box_downscale_2x2_unit abd2_checker u_abd2_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
